// File: hw/rtl/qrs_pkg.sv
package qrs_pkg;

  localparam logic [1:0] KIND_DOUBLE  = 2'd0;
  localparam logic [1:0] KIND_REAL    = 2'd1;
  localparam logic [1:0] KIND_COMPLEX = 2'd2;
  localparam logic [1:0] KIND_NO_A    = 2'd3;

  localparam logic [1:0] SEL_NEG_B = 2'd0;
  localparam logic [1:0] SEL_LOW   = 2'd1;
  localparam logic [1:0] SEL_HIGH  = 2'd2;
  localparam logic [1:0] SEL_IMAG  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       mul_ac;
    logic       mul_bb;
    logic       disc;
    logic       sqrt_start;
    logic       div_start;
    logic [1:0] div_sel;
    logic       store1;
    logic       store2;
    logic       finish;
  } qrs_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic d_zero;
    logic d_neg;
    logic sqrt_done;
    logic div_done;
  } qrs_sts_t;

endpackage

// File: hw/rtl/qrs_sqrt.sv
module qrs_sqrt #(
  parameter int W = 66
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   radicand,
  output logic           done,
  output logic [W/2-1:0] root
);
  localparam int H    = W / 2;
  localparam int R    = H + 3;
  localparam int CNTW = $clog2(H + 1);

  logic [W-1:0]    rad;
  logic [R-1:0]    rem;
  logic [R-1:0]    rem_t;
  logic [R-1:0]    trial;
  logic [CNTW-1:0] cnt;
  logic            running;
  logic            fits;

  assign rem_t = {rem[R-3:0], rad[W-1:W-2]};
  assign trial = R'({root, 2'b01});
  assign fits  = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        root    <= '0;
        rad     <= radicand;
      end else if (running) begin
        rad  <= rad << 2;
        rem  <= fits ? rem_t - trial : rem_t;
        root <= {root[H-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == CNTW'(H - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/qrs_div.sv
module qrs_div #(
  parameter int NW = 50,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   num_sh;
  logic [DW-1:0]   den_q;
  logic [DW-1:0]   rem;
  logic [DW:0]     rem_t;
  logic [DW:0]     diff;
  logic [CNTW-1:0] cnt;
  logic            running;
  logic            fits;

  assign rem_t = {rem, num_sh[NW-1]};
  assign diff  = rem_t - {1'b0, den_q};
  assign fits  = rem_t >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= '0;
        num_sh  <= num;
        den_q   <= den;
      end else if (running) begin
        num_sh <= num_sh << 1;
        rem    <= fits ? diff[DW-1:0] : rem_t[DW-1:0];
        quo    <= {quo[NW-2:0], fits};
        cnt    <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hw/rtl/qrs_dp.sv
module qrs_dp #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        coef_a,
  input  logic [31:0]        coef_b,
  input  logic [31:0]        coef_c,
  input  qrs_pkg::qrs_cmd_t  cmd,
  output qrs_pkg::qrs_sts_t  sts,
  output logic [1:0]         root_kind,
  output logic [31:0]        first_value,
  output logic [31:0]        second_value,
  output logic               saturated
);
  import qrs_pkg::*;

  localparam int PW  = 2 * CW;
  localparam int DWD = 2 * CW + 3;
  localparam int RW  = 2 * CW + 2;
  localparam int SW  = CW + 1;
  localparam int NSW = CW + 3;
  localparam int NMW = CW + 2;
  localparam int NW  = CW + 2 + F;
  localparam int QDW = CW + 1;

  logic signed [CW-1:0]  a, b, c;
  logic signed [PW-1:0]  p, bsq;
  logic signed [DWD-1:0] d;
  logic [DWD-1:0]        dabs;
  logic [SW-1:0]         s;
  logic signed [NSW-1:0] nb, s_ext, n;
  logic [NSW-1:0]        nabs;
  logic [QDW-1:0]        amag;
  logic                  den_neg;
  logic                  neg_q;
  logic [NW-1:0]         q;
  logic [NW-1:0]         lim;
  logic signed [CW-1:0]  vres, v1, v2;
  logic                  vsat, sat_acc;
  logic signed [CW-1:0]  first_q, second_q;

  assign dabs  = d[DWD-1] ? -d : d;
  assign nb    = -NSW'(b);
  assign s_ext = $signed(NSW'(s));
  assign amag  = a[CW-1] ? -QDW'(a) : QDW'(a);
  assign lim   = NW'(1) << (CW - 1);

  always_comb begin
    unique case (cmd.div_sel)
      SEL_NEG_B: n = nb;
      SEL_LOW:   n = nb - s_ext;
      SEL_HIGH:  n = nb + s_ext;
      default:   n = s_ext;
    endcase
    den_neg = (cmd.div_sel == SEL_IMAG) ? 1'b0 : a[CW-1];
    nabs    = n[NSW-1] ? -n : n;
  end

  qrs_sqrt #(.W(RW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (dabs[RW-1:0]),
    .done     (sts.sqrt_done),
    .root     (s)
  );

  qrs_div #(.NW(NW), .DW(QDW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   ({nabs[NMW-1:0], {F{1'b0}}}),
    .den   (amag << 1),
    .done  (sts.div_done),
    .quo   (q)
  );

  always_comb begin
    vsat = 1'b0;
    if (neg_q && q != '0) begin
      if (q > lim) begin
        vsat = 1'b1;
        vres = {1'b1, {(CW-1){1'b0}}};
      end else begin
        vres = -q[CW-1:0];
      end
    end else if (q > lim - 1'b1) begin
      vsat = 1'b1;
      vres = {1'b0, {(CW-1){1'b1}}};
    end else begin
      vres = q[CW-1:0];
    end
  end

  assign sts.a_zero = a == '0;
  assign sts.d_zero = d == '0;
  assign sts.d_neg  = d[DWD-1];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a       <= coef_a[CW-1:0];
      b       <= coef_b[CW-1:0];
      c       <= coef_c[CW-1:0];
      sat_acc <= 1'b0;
    end
    if (cmd.mul_ac) p <= a * c;
    if (cmd.mul_bb) bsq <= b * b;
    if (cmd.disc) d <= DWD'(bsq) - (DWD'(p) <<< 2);
    if (cmd.div_start) neg_q <= n[NSW-1] ^ den_neg;
    if (cmd.store1) begin
      v1      <= vres;
      sat_acc <= sat_acc | vsat;
    end
    if (cmd.store2) begin
      v2      <= vres;
      sat_acc <= sat_acc | vsat;
    end
    if (cmd.finish) begin
      if (sts.a_zero) begin
        root_kind <= KIND_NO_A;
        first_q   <= '0;
        second_q  <= '0;
        saturated <= 1'b0;
      end else if (sts.d_zero) begin
        root_kind <= KIND_DOUBLE;
        first_q   <= v1;
        second_q  <= v1;
        saturated <= sat_acc;
      end else if (!sts.d_neg) begin
        root_kind <= KIND_REAL;
        first_q   <= (v1 > v2) ? v2 : v1;
        second_q  <= (v1 > v2) ? v1 : v2;
        saturated <= sat_acc;
      end else begin
        root_kind <= KIND_COMPLEX;
        first_q   <= v1;
        second_q  <= v2;
        saturated <= sat_acc;
      end
    end
  end

  assign first_value  = 32'(first_q);
  assign second_value = 32'(second_q);
endmodule

// File: hw/rtl/qrs_ctrl.sv
module qrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              valid,
  output qrs_pkg::qrs_cmd_t cmd,
  input  qrs_pkg::qrs_sts_t sts
);
  import qrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_MBB, S_DISC, S_CHECK, S_SQRT, S_DIV1, S_DIV2, S_FIN
  } state_t;

  state_t state;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load   = start;
      S_MAC:   cmd.mul_ac = 1'b1;
      S_MBB:   cmd.mul_bb = 1'b1;
      S_DISC:  cmd.disc   = 1'b1;
      S_CHECK: cmd.sqrt_start = !sts.a_zero;
      S_SQRT: begin
        cmd.div_start = sts.sqrt_done;
        cmd.div_sel   = (sts.d_zero || sts.d_neg) ? SEL_NEG_B : SEL_LOW;
      end
      S_DIV1: begin
        cmd.store1    = sts.div_done;
        cmd.div_start = sts.div_done && !sts.d_zero;
        cmd.div_sel   = sts.d_neg ? SEL_IMAG : SEL_HIGH;
      end
      S_DIV2:  cmd.store2 = sts.div_done;
      default: cmd.finish = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= state == S_FIN;
      unique case (state)
        S_IDLE:  if (start) state <= S_MAC;
        S_MAC:   state <= S_MBB;
        S_MBB:   state <= S_DISC;
        S_DISC:  state <= S_CHECK;
        S_CHECK: state <= sts.a_zero ? S_FIN : S_SQRT;
        S_SQRT:  if (sts.sqrt_done) state <= S_DIV1;
        S_DIV1: begin
          if (sts.div_done) state <= sts.d_zero ? S_FIN : S_DIV2;
        end
        S_DIV2:  if (sts.div_done) state <= S_FIN;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/quadratic_root_solver.sv
// Channel  Handshake         Ports
// in       start & !busy     coef_a, coef_b, coef_c
// out      valid (1 cycle)   root_kind, first_value, second_value, saturated
//
// One item at a time. States S_MAC, S_MBB, S_DISC and S_CHECK form a*c, b*b,
// the discriminant and its class. The bit-serial square root follows, then one
// restoring division for a double root or two otherwise, and S_FIN registers
// the result. When the leading coefficient is zero, S_CHECK goes straight to
// S_FIN. rst is synchronous; busy is low after reset. The receiver cannot stall.
module quadratic_root_solver #(
  parameter int FRAC_BITS  = 16,
  parameter int COEF_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] coef_a,
  input  logic [31:0] coef_b,
  input  logic [31:0] coef_c,
  output logic        valid,
  output logic [1:0]  root_kind,
  output logic [31:0] first_value,
  output logic [31:0] second_value,
  output logic        saturated
);
  import qrs_pkg::*;

  qrs_cmd_t cmd;
  qrs_sts_t sts;

  qrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .cmd   (cmd),
    .sts   (sts)
  );

  qrs_dp #(.CW(COEF_WIDTH), .F(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .coef_c       (coef_c),
    .cmd          (cmd),
    .sts          (sts),
    .root_kind    (root_kind),
    .first_value  (first_value),
    .second_value (second_value),
    .saturated    (saturated)
  );
endmodule

// File: bench/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
    logic        sat;
  } roots_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    bit          typed;
    roots_t      roots;
  } coef_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] coef_a = '0;
  logic [31:0] coef_b = '0;
  logic [31:0] coef_c = '0;
  logic        valid;
  logic [1:0]  root_kind;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic        saturated;

  roots_t pending_roots[$];
  coef_row_t rows[$];
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int kind_hits[4];
  bit sat_seen = 1'b0;

  quadratic_root_solver dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .valid(valid), .root_kind(root_kind), .first_value(first_value),
    .second_value(second_value), .saturated(saturated)
  );

  always #5 clk = ~clk;

  function automatic logic [33:0] isqrt66(logic [65:0] d);
    logic [33:0] r;
    logic [33:0] cand;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      cand = r | (34'd1 << i);
      if ({34'd0, cand} * {34'd0, cand} <= {2'd0, d}) r = cand;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] scaled_div(logic signed [67:0] n,
                                                    logic signed [67:0] d,
                                                    inout logic sat);
    logic [99:0] un;
    logic [99:0] ud;
    logic [99:0] q;
    bit neg;
    un = (n < 0 ? -n : n);
    un = un << FRAC;
    ud = (d < 0 ? -d : d);
    q = un / ud;
    neg = ((n < 0) != (d < 0)) && q != 0;
    if (neg) begin
      if (q > 100'h8000_0000) begin
        sat = 1'b1;
        q = 100'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 100'h7fff_ffff) begin
      sat = 1'b1;
      q = 100'h7fff_ffff;
    end
    return q[31:0];
  endfunction

  function automatic roots_t solve_roots(logic [31:0] ca, logic [31:0] cb,
                                         logic [31:0] cc);
    roots_t r;
    logic signed [67:0] a, b, c, disc, s, ndisc;
    logic signed [31:0] v1, v2, t;
    logic sat;
    a = $signed(ca);
    b = $signed(cb);
    c = $signed(cc);
    sat = 1'b0;
    r = '0;
    if (a == 0) begin
      r.kind = KIND_NO_A;
      return r;
    end
    disc = b * b - 4 * a * c;
    if (disc == 0) begin
      r.kind = KIND_DOUBLE;
      v1 = scaled_div(-b, 2 * a, sat);
      v2 = v1;
    end else if (disc > 0) begin
      r.kind = KIND_REAL;
      s = 68'(isqrt66(disc[65:0]));
      v1 = scaled_div(-b - s, 2 * a, sat);
      v2 = scaled_div(-b + s, 2 * a, sat);
      if (v1 > v2) begin
        t = v1;
        v1 = v2;
        v2 = t;
      end
    end else begin
      r.kind = KIND_COMPLEX;
      ndisc = -disc;
      s = 68'(isqrt66(ndisc[65:0]));
      v1 = scaled_div(-b, 2 * a, sat);
      v2 = scaled_div(s, 2 * (a < 0 ? -a : a), sat);
    end
    r.first = v1;
    r.second = v2;
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic add_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                         bit typed = 1'b0, roots_t roots = '0);
    coef_row_t row;
    row.a = a;
    row.b = b;
    row.c = c;
    row.typed = typed;
    row.roots = roots;
    rows.push_back(row);
  endtask

  // start stays high after the accepting edge until the next item or the end
  task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    start <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_roots.push_back(solve_roots(a, b, c));
    items_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    roots_t want;
    if (!rst && valid) begin
      results_seen++;
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected result", first_value, 32'h0);
      end else begin
        want = pending_roots.pop_front();
        kind_hits[root_kind]++;
        if (saturated) sat_seen = 1'b1;
        if (root_kind !== want.kind) report_mismatch("root_kind", root_kind, want.kind);
        if (first_value !== want.first) report_mismatch("first_value", first_value, want.first);
        if (second_value !== want.second)
          report_mismatch("second_value", second_value, want.second);
        if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no activity for %0d cycles", idle_cycles);
        $display("FAIL quadratic_root_solver");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      3: return $signed($urandom_range(0, 8)) * 32'sh0001_0000 - 32'sh0004_0000;
      4: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
      default: return $urandom & 32'hffff_0000;
    endcase
  endfunction

  initial begin
    roots_t want;
    logic [31:0] a, b, c, r1, r2;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    add_row(32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, '{KIND_NO_A, 0, 0, 0});
    add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{KIND_NO_A, 0, 0, 0});
    add_row(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{KIND_DOUBLE, 0, 0, 0});
    add_row(32'h0001_0000, 32'hfffc_0000, 32'h0004_0000, 1'b1,
            '{KIND_DOUBLE, 32'h0002_0000, 32'h0002_0000, 0});
    add_row(32'h0001_0000, 32'h0000_0000, 32'hfffc_0000, 1'b1,
            '{KIND_REAL, 32'hfffe_0000, 32'h0002_0000, 0});
    add_row(32'h0001_0000, 32'h0000_0000, 32'h0004_0000, 1'b1,
            '{KIND_COMPLEX, 32'h0000_0000, 32'h0002_0000, 0});
    add_row(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0000);
    add_row(32'h0000_0001, 32'h8000_0000, 32'h0000_0000);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000);
    add_row(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_row(32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff);
    add_row(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000);
    add_row(32'h0000_0003, 32'h0000_0007, 32'h0000_0002);
    add_row(32'h8000_0000, 32'h0000_0000, 32'h0000_0001);

    foreach (rows[i]) begin
      send_item(rows[i].a, rows[i].b, rows[i].c, 1'b1);
      if (rows[i].typed) begin
        want = solve_roots(rows[i].a, rows[i].b, rows[i].c);
        if (want !== rows[i].roots)
          report_mismatch("typed row prediction", want.first, rows[i].roots.first);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // build from chosen roots so real and double cases turn up often
          a = $signed($urandom_range(1, 4)) * ($urandom_range(0, 1) ? 1 : -1);
          r1 = $signed($urandom_range(0, 40)) - 20;
          r2 = ($urandom_range(0, 2) == 0) ? r1 : $signed($urandom_range(0, 40)) - 20;
          b = -a * (r1 + r2) * 32'sh0001_0000;
          c = a * r1 * r2 * 32'sh0001_0000;
          a = a * 32'sh0001_0000;
        end
        3: begin
          a = rand_coef();
          b = 32'h0;
          c = rand_coef();
        end
        default: begin
          a = rand_coef();
          b = rand_coef();
          c = rand_coef();
        end
      endcase
      send_item(a, b, c, n < RANDOM_ITEMS - 60);
    end
    start <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("kinds double/real/complex/no-a: %0d/%0d/%0d/%0d, clipping seen: %0d",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], sat_seen);
    if (mismatches == 0 && pending_roots.size() == 0) begin
      $display("PASS quadratic_root_solver");
    end else begin
      $display("FAIL quadratic_root_solver");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/qrs_dp.sv
hw/rtl/qrs_ctrl.sv
hw/rtl/quadratic_root_solver.sv
bench/quadratic_root_solver_tb.sv
